// ===== rtl/core/size_class_block_allocator_assert.svh =====
// Assertion macros for the size-class block allocator.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define SCBA_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCBA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCBA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SCBA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/scba_pkg.sv =====
// Package with shared types, constants and the class table of the allocator.
package scba_pkg;
  localparam int NUM_CLASSES = 21;
  localparam int REFILL_BLOCKS = 16;
  localparam int LOCAL_DEPTH = 32;
  localparam int GLOBAL_DEPTH = 256;
  localparam int ADDR_BITS = 48;
  localparam int SPILL_BLOCKS = 16;
  localparam int CLS_W = 5;
  localparam int FLD_W = 48;
  localparam int CFG_W = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] FN_CALLOC = 2'd0;
  localparam logic [1:0] FN_CFREE = 2'd1;
  localparam logic [1:0] FN_DALLOC = 2'd2;
  localparam logic [1:0] FN_DFREE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BATCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE = 3'b001,
    OP_G2L = 3'b010,
    OP_L2G = 3'b100
  } move_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic carve;
    logic move_g2l;
    logic move_l2g;
    logic pop_local;
    logic pop_global;
    logic push_local;
    logic push_global;
    logic bump_offset;
    logic finish;
    logic [1:0] status;
  } scba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic addr_zero;
    logic local_empty;
    logic global_empty;
    logic local_at_limit;
    logic local_below_limit;
    logic spill_fits;
    logic global_full;
    logic refill_fits;
    logic region_fits;
    logic carve_last;
    logic spill_last;
    logic rd_busy;
  } scba_stat_t;

  function automatic logic [22:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [22:0] b;
    case (c)
      5'd0: b = 23'd8;
      5'd1: b = 23'd16;
      5'd2: b = 23'd32;
      5'd3: b = 23'd48;
      5'd4: b = 23'd64;
      5'd5: b = 23'd80;
      5'd6: b = 23'd96;
      5'd7: b = 23'd112;
      5'd8: b = 23'd128;
      5'd9: b = 23'd192;
      5'd10: b = 23'd256;
      5'd11: b = 23'd512;
      5'd12: b = 23'd1024;
      5'd13: b = 23'd2048;
      5'd14: b = 23'd4096;
      5'd15: b = 23'd8192;
      5'd16: b = 23'd16384;
      5'd17: b = 23'd32768;
      5'd18: b = 23'd65536;
      5'd19: b = 23'd1048576;
      default: b = 23'd4194304;
    endcase
    return b;
  endfunction

  function automatic logic [CLS_W-1:0] pick_class(input logic [31:0] s);
    logic [CLS_W-1:0] r;
    r = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if ({9'd0, s} <= {18'd0, class_bytes(CLS_W'(i))}) r = CLS_W'(i);
    end
    return r;
  endfunction
endpackage

// ===== rtl/core/scba_if.sv =====
// Valid/ready channel interface carrying one beat of payload.
interface scba_if #(parameter type PAYLOAD_T = logic);
  logic valid;
  logic ready;
  PAYLOAD_T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/scba_datapath.sv =====
// Datapath: class stacks, counts, carving pointer and the result register.
module scba_datapath #(
  parameter int REFILL_BLOCKS = scba_pkg::REFILL_BLOCKS,
  parameter int LOCAL_DEPTH = scba_pkg::LOCAL_DEPTH,
  parameter int GLOBAL_DEPTH = scba_pkg::GLOBAL_DEPTH,
  parameter int ADDR_BITS = scba_pkg::ADDR_BITS
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [scba_pkg::CFG_W-1:0] cfg_data,
  input logic [1:0] in_func,
  input logic [31:0] in_size,
  input logic [scba_pkg::FLD_W-1:0] in_addr,
  input scba_pkg::scba_cmd_t cmd,
  output scba_pkg::scba_stat_t stat,
  output logic [scba_pkg::FLD_W-1:0] res_addr,
  output logic [1:0] res_status,
  output logic [scba_pkg::CLS_W-1:0] res_class
);
  import scba_pkg::*;
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);
  localparam int GCW = $clog2(GLOBAL_DEPTH + 1);
  localparam int RW = $clog2(REFILL_BLOCKS + 1);
  localparam int LMEM = NUM_CLASSES * LOCAL_DEPTH;
  localparam int GMEM = NUM_CLASSES * GLOBAL_DEPTH;
  localparam int LAW = $clog2(LMEM);
  localparam int GAW = $clog2(GMEM);

  logic [ADDR_BITS-1:0] local_mem [LMEM];
  logic [ADDR_BITS-1:0] global_mem [GMEM];
  logic [LCW-1:0] local_count [NUM_CLASSES];
  logic [GCW-1:0] global_count [NUM_CLASSES];
  logic [ADDR_BITS-1:0] carve_offset;
  logic [5:0] batch_max;
  logic [47:0] region_base;
  logic [47:0] region_length;

  logic [1:0] func;
  logic [CLS_W-1:0] cls;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] total;
  logic [ADDR_BITS-1:0] carve_ptr;
  logic [RW-1:0] carve_n;
  logic [4:0] spill_n;
  logic [ADDR_BITS-1:0] rd_l;
  logic [ADDR_BITS-1:0] rd_g;
  logic rd_l_v;
  logic rd_g_v;

  logic [LCW-1:0] lc;
  logic [GCW-1:0] gc;
  logic [LCW-1:0] limit;
  logic [ADDR_BITS:0] room;
  logic [4:0] spill_req;
  logic [GCW-1:0] gfree;

  assign lc = local_count[cls];
  assign gc = global_count[cls];
  assign total = ADDR_BITS'(class_bytes(cls)) * ADDR_BITS'(REFILL_BLOCKS);

  always_comb begin
    if (batch_max == 6'd0) limit = LCW'(1);
    else if ({26'd0, batch_max} > LOCAL_DEPTH) limit = LCW'(LOCAL_DEPTH);
    else limit = LCW'(batch_max);
    spill_req = ({{(32-LCW){1'b0}}, lc} < SPILL_BLOCKS) ? 5'(lc) : 5'(SPILL_BLOCKS);
    gfree = GCW'(GLOBAL_DEPTH) - gc;
    room = {1'b0, ADDR_BITS'(region_length)} - {1'b0, carve_offset};
  end

  always_comb begin
    stat.func = func;
    stat.addr_zero = (addr == '0);
    stat.local_empty = (lc == '0);
    stat.global_empty = (gc == '0);
    stat.local_at_limit = (lc >= limit);
    stat.local_below_limit = (lc < limit);
    stat.spill_fits = ({{(GCW){1'b0}}, spill_req} <= {5'd0, gfree});
    stat.global_full = (gc >= GCW'(GLOBAL_DEPTH));
    stat.refill_fits = ({{(32-GCW){1'b0}}, gfree} >= REFILL_BLOCKS);
    stat.region_fits = !room[ADDR_BITS] && (total <= room[ADDR_BITS-1:0]);
    stat.carve_last = (carve_n == RW'(REFILL_BLOCKS - 1));
    stat.spill_last = (spill_n == 5'(SPILL_BLOCKS - 1));
    stat.rd_busy = rd_l_v || rd_g_v;
  end

  // Read ports of the two stacks; top entries, data registered on a pop.
  always_ff @(posedge clk) begin
    if (cmd.pop_local)
      rd_l <= local_mem[LAW'(cls) * LAW'(LOCAL_DEPTH) + LAW'(lc - LCW'(1))];
    if (cmd.pop_global)
      rd_g <= global_mem[GAW'(cls) * GAW'(GLOBAL_DEPTH) + GAW'(gc - GCW'(1))];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_local)
      local_mem[LAW'(cls) * LAW'(LOCAL_DEPTH) + LAW'(lc)] <= cmd.move_g2l ? rd_g : addr;
    if (cmd.push_global || cmd.carve)
      global_mem[GAW'(cls) * GAW'(GLOBAL_DEPTH) + GAW'(gc)] <=
        cmd.carve ? carve_ptr : (cmd.move_l2g ? rd_l : addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        local_count[i] <= '0;
        global_count[i] <= '0;
      end
      carve_offset <= '0;
      batch_max <= 6'd32;
      region_base <= '0;
      region_length <= '0;
      rd_l_v <= 1'b0;
      rd_g_v <= 1'b0;
    end else begin
      rd_l_v <= cmd.pop_local;
      rd_g_v <= cmd.pop_global;
      if (cfg_we) begin
        case (cfg_index)
          REG_BATCH: batch_max <= cfg_data[5:0];
          REG_BASE: region_base <= cfg_data[47:0];
          REG_LEN: region_length <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (cmd.pop_local) local_count[cls] <= lc - LCW'(1);
      else if (cmd.push_local) local_count[cls] <= lc + LCW'(1);
      if (cmd.pop_global) global_count[cls] <= gc - GCW'(1);
      else if (cmd.push_global || cmd.carve) global_count[cls] <= gc + GCW'(1);
      if (cmd.bump_offset) carve_offset <= carve_offset + total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      cls <= pick_class(in_size);
      addr <= ADDR_BITS'(in_addr);
      carve_n <= '0;
      spill_n <= '0;
    end else begin
      if (cmd.carve) carve_n <= carve_n + RW'(1);
      if (cmd.move_l2g && cmd.push_global) spill_n <= spill_n + 5'd1;
    end
    if (!cmd.carve) carve_ptr <= ADDR_BITS'(region_base) + carve_offset;
    else carve_ptr <= carve_ptr + ADDR_BITS'(class_bytes(cls));
    if (cmd.finish) begin
      res_status <= cmd.status;
      res_class <= cls;
      res_addr <= (cmd.status == ST_OK && (func == FN_CALLOC || func == FN_DALLOC)) ?
        FLD_W'(func == FN_CALLOC ? rd_l : rd_g) : '0;
    end
  end
endmodule

// ===== rtl/core/scba_ctrl.sv =====
// Controller state machine sequencing refills, batch moves and spills.
module scba_ctrl (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input logic out_ready,
  input scba_pkg::scba_stat_t stat,
  output scba_pkg::scba_cmd_t cmd
);
  import scba_pkg::*;
  `include "size_class_block_allocator_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_CARVE = 10'b0000000100,
    S_FILL = 10'b0000001000,
    S_FILLW = 10'b0000010000,
    S_SPILL = 10'b0000100000,
    S_SPILLW = 10'b0001000000,
    S_POP = 10'b0010000000,
    S_POPW = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] st, st_next;
  logic out_full;

  always_comb begin
    state_next = state;
    st_next = st;
    cmd = '0;
    cmd.status = st;
    case (state)
      S_IDLE: begin
        if (in_valid && !out_full) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        // Class, limits and carve total settle here from the loaded request.
        st_next = ST_OK;
        case (stat.func)
          FN_CALLOC: begin
            if (!stat.local_empty) state_next = S_POP;
            else if (stat.global_empty) begin
              if (!stat.refill_fits) begin st_next = ST_FULL; state_next = S_DONE; end
              else if (!stat.region_fits) begin st_next = ST_OOM; state_next = S_DONE; end
              else state_next = S_CARVE;
            end else state_next = S_FILL;
          end
          FN_DALLOC: begin
            if (!stat.global_empty) state_next = S_POP;
            else if (!stat.refill_fits) begin st_next = ST_FULL; state_next = S_DONE; end
            else if (!stat.region_fits) begin st_next = ST_OOM; state_next = S_DONE; end
            else state_next = S_CARVE;
          end
          FN_CFREE: begin
            if (stat.addr_zero) begin st_next = ST_NULL; state_next = S_DONE; end
            else if (!stat.local_at_limit) state_next = S_DONE;
            else if (!stat.spill_fits) begin st_next = ST_FULL; state_next = S_DONE; end
            else state_next = S_SPILL;
          end
          default: begin
            if (stat.addr_zero) begin st_next = ST_NULL; state_next = S_DONE; end
            else if (stat.global_full) begin st_next = ST_FULL; state_next = S_DONE; end
            else state_next = S_DONE;
          end
        endcase
      end
      S_CARVE: begin
        cmd.carve = 1'b1;
        if (stat.carve_last) begin
          cmd.bump_offset = 1'b1;
          state_next = (stat.func == FN_CALLOC) ? S_FILL : S_POP;
        end
      end
      S_FILL: begin
        if (stat.local_below_limit && !stat.global_empty) begin
          cmd.pop_global = 1'b1;
          state_next = S_FILLW;
        end else state_next = S_POP;
      end
      S_FILLW: begin
        cmd.move_g2l = 1'b1;
        cmd.push_local = 1'b1;
        state_next = S_FILL;
      end
      S_SPILL: begin
        cmd.pop_local = 1'b1;
        state_next = S_SPILLW;
      end
      S_SPILLW: begin
        cmd.move_l2g = 1'b1;
        cmd.push_global = 1'b1;
        state_next = (stat.spill_last || stat.local_empty) ? S_DONE : S_SPILL;
      end
      S_POP: begin
        if (stat.func == FN_CALLOC) cmd.pop_local = 1'b1;
        else cmd.pop_global = 1'b1;
        state_next = S_POPW;
      end
      S_POPW: begin
        if (!stat.rd_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (st == ST_OK && stat.func == FN_CFREE) cmd.push_local = 1'b1;
        if (st == ST_OK && stat.func == FN_DFREE) cmd.push_global = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st <= ST_OK;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      st <= st_next;
      if (cmd.finish) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;

  `SCBA_ASSERT_IMPL(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `SCBA_ASSERT_IMPL(a_no_finish_full, clk, rst, cmd.finish |-> !out_full, "result overwritten")
  `SCBA_ASSERT_IMPL(a_accept_busy, clk, rst, (in_valid && in_ready) |=> !in_ready, "busy")
endmodule

// ===== rtl/core/size_class_block_allocator.sv =====
// Size-class block allocator with per-class local caches and global pools.
//
// Requests arrive on the req channel (valid/ready); each gives exactly one beat
// on the rsp channel with the granted address, status and size class.
// Configuration registers are written by cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// One request is worked on at a time; the next is taken after its result leaves.
// A hit on a local or global stack is read out in the pop and wait states, and a
// free that needs no spill goes from decode straight to the result.
// A refill carves REFILL_BLOCKS blocks at one per cycle, and a batch move or a
// spill moves each block through the stack read port in a pop and a write state.
// Reset clears all counts, the carving offset and the configuration registers to defaults.
// When the receiver stalls, the result waits in the output register and no new
// request is taken until it has been accepted.
module size_class_block_allocator #(
  parameter int REFILL_BLOCKS = scba_pkg::REFILL_BLOCKS,
  parameter int LOCAL_DEPTH = scba_pkg::LOCAL_DEPTH,
  parameter int GLOBAL_DEPTH = scba_pkg::GLOBAL_DEPTH,
  parameter int ADDR_BITS = scba_pkg::ADDR_BITS
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [scba_pkg::CFG_W-1:0] cfg_data,
  scba_if.sink req,
  scba_if.source rsp
);
  import scba_pkg::*;

  scba_cmd_t cmd;
  scba_stat_t stat;

  scba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  scba_datapath #(
    .REFILL_BLOCKS(REFILL_BLOCKS), .LOCAL_DEPTH(LOCAL_DEPTH),
    .GLOBAL_DEPTH(GLOBAL_DEPTH), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_func(req.data.func), .in_size(req.data.req_size),
    .in_addr(req.data.block_addr),
    .cmd(cmd), .stat(stat),
    .res_addr(rsp.data.granted_addr), .res_status(rsp.data.status),
    .res_class(rsp.data.size_class)
  );
endmodule
